@@ rtl/jedt_pkg.sv @@
// Shared types, constants and arithmetic helpers of the joystick event table.
// Used by the channel interfaces, the top level and the checker.
package jedt_pkg;

  localparam int AXIS_SLOTS   = 64;
  localparam int BUTTON_SLOTS = 128;

  localparam int AXIS_AW   = (AXIS_SLOTS > 1) ? $clog2(AXIS_SLOTS) : 1;
  localparam int BUTTON_AW = (BUTTON_SLOTS > 1) ? $clog2(BUTTON_SLOTS) : 1;

  localparam int AXIS_CNT_W   = $clog2(AXIS_SLOTS + 1);
  localparam int BUTTON_CNT_W = $clog2(BUTTON_SLOTS + 1);

  localparam int AXIS_COUNT_FW   = 7;
  localparam int BUTTON_COUNT_FW = 8;

  localparam int DEAD_BAND_W = 15;
  localparam int GAIN_W      = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 1;

  localparam logic [7:0] TYPE_BUTTON = 8'h01;
  localparam logic [7:0] TYPE_AXIS   = 8'h02;
  localparam logic [7:0] TYPE_INIT   = 8'h80;

  localparam logic [DEAD_BAND_W-1:0] DEAD_BAND_RESET = '0;
  localparam logic [GAIN_W-1:0]      GAIN_RESET      = 32'd65538;

  typedef enum logic [0:0] {
    OP_EVENT = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE         = 2'd0,
    ST_BAD_LENGTH   = 2'd1,
    ST_UNKNOWN_TYPE = 2'd2,
    ST_BEYOND_STORE = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DEAD_BAND = 1'b0,
    CFG_GAIN      = 1'b1
  } cfg_index_t;

  // remove the deadzone band, shifting the outer ranges toward zero
  function automatic logic signed [16:0] deadzone(logic signed [15:0] raw,
                                                  logic [DEAD_BAND_W-1:0] band);
    logic signed [16:0] r;
    logic signed [16:0] b;
    r = 17'(raw);
    b = signed'({2'b00, band});
    if (r > b) begin
      return r - b;
    end else if (r < -b) begin
      return r + b;
    end else begin
      return '0;
    end
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [33:0] x);
    if (x > 34'sd32767) begin
      return 16'sh7fff;
    end else if (x < -34'sd32768) begin
      return 16'sh8000;
    end else begin
      return x[15:0];
    end
  endfunction

endpackage

@@ rtl/jedt_channels.sv @@
// Valid/ready channel interfaces: event input, result output, register writes.
// Depends on jedt_pkg for field widths.
interface jedt_event_if;
  logic               valid;
  logic               ready;
  logic [0:0]         operation;
  logic               frame_ok;
  logic [7:0]         event_type;
  logic [7:0]         index;
  logic signed [15:0] raw_value;

  modport source (output valid, operation, frame_ok, event_type, index, raw_value,
                  input ready);
  modport sink (input valid, operation, frame_ok, event_type, index, raw_value,
                output ready);
endinterface

interface jedt_result_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             status;
  logic signed [15:0]                     axis_value;
  logic                                   button_value;
  logic [jedt_pkg::AXIS_COUNT_FW-1:0]     axis_count;
  logic [jedt_pkg::BUTTON_COUNT_FW-1:0]   button_count;

  modport source (output valid, status, axis_value, button_value, axis_count,
                  button_count, input ready);
  modport sink (input valid, status, axis_value, button_value, axis_count,
                button_count, output ready);
endinterface

interface jedt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [jedt_pkg::CFG_INDEX_W-1:0] index;
  logic [jedt_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/joystick_event_deadzone_table.sv @@
// Joystick event table: deadzone scaling of axis events, button states, reads.
// Depends on jedt_pkg, jedt_channels (interfaces) and jedt_ram.
//
// Usage:
//   events  - input transactions: a joystick event (operation 0) updates the
//             button or axis store at index; a read request (operation 1)
//             only looks up index. Every transaction yields one result.
//   results - status, the stored axis and button values at index after any
//             update (0 at or beyond the respective count), and both counts.
//   cfg     - register writes: index 0 dead_band, index 1 gain. Write only
//             while no transaction is in flight. ready is always high.
//   Path: a transaction accepted on events passes the input register,
//             the multiply register and the result register to results.
//   Throughput: one transaction per cycle while results.ready is high; the
//             single 17x33 multiply and the registered store read set a three-stage pipeline.
//   Reset (rst, synchronous): clears both stores through per-entry written
//             flags, both counts, and restores dead_band 0, gain 65538.
//   Stall: with results.ready low the result register holds; the stages
//             behind it fill, and events.ready drops once all three hold
//             a transaction.
module joystick_event_deadzone_table (
  input  logic                  clk,
  input  logic                  rst,
  jedt_event_if.sink            events,
  jedt_result_if.source         results,
  jedt_cfg_if.sink              cfg
);

  localparam int AAW = jedt_pkg::AXIS_AW;
  localparam int BAW = jedt_pkg::BUTTON_AW;
  localparam int ACW = jedt_pkg::AXIS_CNT_W;
  localparam int BCW = jedt_pkg::BUTTON_CNT_W;

  // configuration
  logic [jedt_pkg::DEAD_BAND_W-1:0] dead_band;
  logic [jedt_pkg::GAIN_W-1:0]      gain;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_band <= jedt_pkg::DEAD_BAND_RESET;
      gain      <= jedt_pkg::GAIN_RESET;
    end else if (cfg.valid) begin
      unique case (jedt_pkg::cfg_index_t'(cfg.index))
        jedt_pkg::CFG_DEAD_BAND: dead_band <= cfg.data[jedt_pkg::DEAD_BAND_W-1:0];
        jedt_pkg::CFG_GAIN:      gain      <= cfg.data[jedt_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow
  logic a_valid, b_valid, o_valid;
  logic out_free, b_free, a_free;
  logic a_move, b_move;

  assign out_free     = !o_valid || results.ready;
  assign b_free       = !b_valid || out_free;
  assign a_free       = !a_valid || b_free;
  assign events.ready = a_free;
  assign a_move       = a_valid && b_free;
  assign b_move       = b_valid && out_free;

  // stage A: input register
  jedt_pkg::op_t      a_op;
  logic               a_ok;
  logic [7:0]         a_type;
  logic [7:0]         a_idx;
  logic signed [15:0] a_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= events.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (events.valid && a_free) begin
      a_op   <= jedt_pkg::op_t'(events.operation);
      a_ok   <= events.frame_ok;
      a_type <= events.event_type;
      a_idx  <= events.index;
      a_raw  <= events.raw_value;
    end
  end

  // stage A: decode and multiply
  logic [7:0]           a_base;
  logic                 a_fits_axis, a_fits_button;
  jedt_pkg::status_t    a_status;
  logic                 a_wr_button, a_wr_axis, a_grow_axis;
  logic signed [16:0]   a_v;
  logic signed [32:0]   a_gain_s;
  logic signed [49:0]   a_prod;

  assign a_base        = a_type & ~jedt_pkg::TYPE_INIT;
  assign a_fits_axis   = {1'b0, a_idx} < 9'(jedt_pkg::AXIS_SLOTS);
  assign a_fits_button = {1'b0, a_idx} < 9'(jedt_pkg::BUTTON_SLOTS);

  always_comb begin
    a_status    = jedt_pkg::ST_DONE;
    a_wr_button = 1'b0;
    a_wr_axis   = 1'b0;
    a_grow_axis = 1'b0;
    if (a_op == jedt_pkg::OP_EVENT) begin
      priority if (!a_ok) begin
        a_status = jedt_pkg::ST_BAD_LENGTH;
      end else if (a_base == jedt_pkg::TYPE_BUTTON) begin
        if (!a_fits_button) begin
          a_status = jedt_pkg::ST_BEYOND_STORE;
        end else begin
          a_wr_button = 1'b1;
        end
      end else if (a_base == jedt_pkg::TYPE_AXIS) begin
        if (!a_fits_axis) begin
          a_status = jedt_pkg::ST_BEYOND_STORE;
        end else begin
          a_grow_axis = 1'b1;
          a_wr_axis   = (a_type & jedt_pkg::TYPE_INIT) == 8'h00;
        end
      end else begin
        a_status = jedt_pkg::ST_UNKNOWN_TYPE;
      end
    end
  end

  assign a_v      = jedt_pkg::deadzone(a_raw, dead_band);
  assign a_gain_s = signed'({1'b0, gain});
  assign a_prod   = a_v * a_gain_s;

  // stage B: registered product and decode
  jedt_pkg::status_t  b_status;
  logic [7:0]         b_idx;
  logic               b_wr_button, b_button_val, b_wr_axis, b_grow_axis;
  logic signed [49:0] b_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_status     <= a_status;
      b_idx        <= a_idx;
      b_wr_button  <= a_wr_button;
      b_button_val <= a_raw != 16'sd0;
      b_wr_axis    <= a_wr_axis;
      b_grow_axis  <= a_grow_axis;
      b_prod       <= a_prod;
    end
  end

  // stores
  logic [AAW-1:0]     b_aidx;
  logic [BAW-1:0]     b_bidx;
  logic signed [49:0] b_neg;
  logic signed [15:0] b_q;
  logic               axis_we, button_we;
  logic [15:0]        axis_rdata;
  logic [0:0]         button_rdata;

  assign b_aidx    = b_idx[AAW-1:0];
  assign b_bidx    = b_idx[BAW-1:0];
  assign b_neg     = -b_prod;
  assign b_q       = jedt_pkg::sat16(b_neg[49:16]);
  assign axis_we   = b_move && b_wr_axis;
  assign button_we = b_move && b_wr_button;

  jedt_ram #(.WIDTH(16), .DEPTH(jedt_pkg::AXIS_SLOTS)) u_axis_ram (
    .clk   (clk),
    .we    (axis_we),
    .waddr (b_aidx),
    .wdata (b_q),
    .re    (a_move),
    .raddr (a_idx[AAW-1:0]),
    .rdata (axis_rdata)
  );

  jedt_ram #(.WIDTH(1), .DEPTH(jedt_pkg::BUTTON_SLOTS)) u_button_ram (
    .clk   (clk),
    .we    (button_we),
    .waddr (b_bidx),
    .wdata (b_button_val),
    .re    (a_move),
    .raddr (a_idx[BAW-1:0]),
    .rdata (button_rdata)
  );

  // written flags and last-write bypass
  logic [jedt_pkg::AXIS_SLOTS-1:0]   axis_written;
  logic [jedt_pkg::BUTTON_SLOTS-1:0] button_written;
  logic                              lw_axis_valid, lw_button_valid;
  logic [AAW-1:0]                    lw_axis_addr;
  logic [BAW-1:0]                    lw_button_addr;
  logic [15:0]                       lw_axis_data;
  logic                              lw_button_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_written    <= '0;
      button_written  <= '0;
      lw_axis_valid   <= 1'b0;
      lw_button_valid <= 1'b0;
    end else begin
      if (axis_we) begin
        axis_written[b_aidx] <= 1'b1;
        lw_axis_valid        <= 1'b1;
      end
      if (button_we) begin
        button_written[b_bidx] <= 1'b1;
        lw_button_valid        <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (axis_we) begin
      lw_axis_addr <= b_aidx;
      lw_axis_data <= b_q;
    end
    if (button_we) begin
      lw_button_addr <= b_bidx;
      lw_button_data <= b_button_val;
    end
  end

  // counts
  logic [ACW-1:0] axes_seen, axes_next;
  logic [BCW-1:0] buttons_seen, buttons_next;

  always_comb begin
    axes_next    = axes_seen;
    buttons_next = buttons_seen;
    if (b_grow_axis && ({1'b0, b_idx} >= 9'(axes_seen))) begin
      axes_next = ACW'({1'b0, b_idx} + 9'd1);
    end
    if (b_wr_button && ({1'b0, b_idx} >= 9'(buttons_seen))) begin
      buttons_next = BCW'({1'b0, b_idx} + 9'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axes_seen    <= '0;
      buttons_seen <= '0;
    end else if (b_move) begin
      axes_seen    <= axes_next;
      buttons_seen <= buttons_next;
    end
  end

  // stage B: value lookup after update
  logic [15:0] axis_mem_val, axis_entry, axis_out;
  logic        button_mem_val, button_entry, button_out;

  always_comb begin
    axis_mem_val = (lw_axis_valid && lw_axis_addr == b_aidx) ? lw_axis_data : axis_rdata;
    button_mem_val = (lw_button_valid && lw_button_addr == b_bidx) ? lw_button_data
                                                                   : button_rdata[0];
    if (b_wr_axis) begin
      axis_entry = b_q;
    end else if (axis_written[b_aidx]) begin
      axis_entry = axis_mem_val;
    end else begin
      axis_entry = '0;
    end
    if (b_wr_button) begin
      button_entry = b_button_val;
    end else if (button_written[b_bidx]) begin
      button_entry = button_mem_val;
    end else begin
      button_entry = 1'b0;
    end
    axis_out   = ({1'b0, b_idx} < 9'(axes_next)) ? axis_entry : '0;
    button_out = ({1'b0, b_idx} < 9'(buttons_next)) ? button_entry : 1'b0;
  end

  // result register
  jedt_pkg::status_t                   o_status;
  logic [15:0]                         o_axis;
  logic                                o_button;
  logic [jedt_pkg::AXIS_COUNT_FW-1:0]  o_axis_count;
  logic [jedt_pkg::BUTTON_COUNT_FW-1:0] o_button_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_free) begin
      o_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      o_status       <= b_status;
      o_axis         <= axis_out;
      o_button       <= button_out;
      o_axis_count   <= jedt_pkg::AXIS_COUNT_FW'(axes_next);
      o_button_count <= jedt_pkg::BUTTON_COUNT_FW'(buttons_next);
    end
  end

  assign results.valid        = o_valid;
  assign results.status       = o_status;
  assign results.axis_value   = o_axis;
  assign results.button_value = o_button;
  assign results.axis_count   = o_axis_count;
  assign results.button_count = o_button_count;

endmodule

@@ rtl/jedt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module jedt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/jedt_checker.sv @@
// Port-level checks of the joystick event table, bound to the top level.
// Depends on jedt_pkg and joystick_event_deadzone_table.
module jedt_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [1:0]                           status,
  input logic [15:0]                          axis_value,
  input logic                                 button_value,
  input logic [jedt_pkg::AXIS_COUNT_FW-1:0]   axis_count,
  input logic [jedt_pkg::BUTTON_COUNT_FW-1:0] button_count
);

  logic                                 in_acc, out_acc;
  logic [1:0]                           outstanding;
  logic [jedt_pkg::AXIS_COUNT_FW-1:0]   last_axis_count;
  logic [jedt_pkg::BUTTON_COUNT_FW-1:0] last_button_count;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding       <= '0;
      last_axis_count   <= '0;
      last_button_count <= '0;
    end else begin
      outstanding <= 2'(outstanding + {1'b0, in_acc} - {1'b0, out_acc});
      if (out_acc) begin
        last_axis_count   <= axis_count;
        last_button_count <= button_count;
      end
    end
  end

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outstanding != 2'd0)
    else $error("result shown with no transaction in flight");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !out_acc) |-> outstanding != 2'd3)
    else $error("transaction accepted beyond pipeline capacity");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(axis_value)
      && $stable(button_value) && $stable(axis_count) && $stable(button_count))
    else $error("stalled result changed");

  a_counts_grow: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> axis_count >= last_axis_count && button_count >= last_button_count
      && 32'(axis_count) <= jedt_pkg::AXIS_SLOTS
      && 32'(button_count) <= jedt_pkg::BUTTON_SLOTS)
    else $error("count shrank or exceeded its store");

endmodule

bind joystick_event_deadzone_table jedt_checker u_jedt_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (events.valid),
  .in_ready     (events.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .status       (results.status),
  .axis_value   (results.axis_value),
  .button_value (results.button_value),
  .axis_count   (results.axis_count),
  .button_count (results.button_count)
);
